>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers used by the checker file qtu_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion held off while reset is high
`define QTU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion checked during reset as well
`define QTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/qtu_pkg.sv
// ----------------------------------------------------------------------------
// qtu_pkg
// types, microcode table and arithmetic helpers of the q table update block
// ----------------------------------------------------------------------------
`default_nettype none

package qtu_pkg;

  localparam logic CFG_LEARNING_RATE   = 1'b0;
  localparam logic CFG_DISCOUNT_FACTOR = 1'b1;

  localparam logic [16:0] LR_RESET   = 17'd6554;
  localparam logic [16:0] DF_RESET   = 17'd58982;
  localparam logic [16:0] RATE_ONE   = 17'd65536;

  typedef enum logic [3:0] {
    STEP_CLR,
    STEP_IDLE,
    STEP_RD_Q,
    STEP_RD_N0,
    STEP_RD_NL,
    STEP_RD_LAST,
    STEP_MUL_G,
    STEP_TGT,
    STEP_DIFF,
    STEP_MUL_A,
    STEP_NEWQ,
    STEP_WR,
    STEP_SQ,
    STEP_OUT
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_WAIT_IN,
    COND_CLR_MORE,
    COND_SCAN_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t jump;
    step_t next;
    logic  in_ready;
    logic  clr_wr;
    logic  rd_next;
    logic  ld_q;
    logic  cmp_best;
    logic  mul_g;
    logic  ld_tgt;
    logic  ld_diff;
    logic  mul_a;
    logic  ld_newq;
    logic  q_wr;
    logic  ld_sq;
    logic  ld_out;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic clr_last;
    logic scan_last;
    logic out_busy;
  } status_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '0;
    case (step)
      STEP_CLR: begin
        w.cond = COND_CLR_MORE; w.jump = STEP_CLR; w.next = STEP_IDLE;
        w.clr_wr = 1'b1;
      end
      STEP_IDLE: begin
        w.cond = COND_WAIT_IN; w.jump = STEP_IDLE; w.next = STEP_RD_Q;
        w.in_ready = 1'b1;
      end
      STEP_RD_Q: begin
        w.cond = COND_ALWAYS; w.jump = STEP_RD_N0; w.next = STEP_RD_N0;
      end
      STEP_RD_N0: begin
        w.cond = COND_ALWAYS; w.jump = STEP_RD_NL; w.next = STEP_RD_NL;
        w.rd_next = 1'b1; w.ld_q = 1'b1;
      end
      STEP_RD_NL: begin
        w.cond = COND_SCAN_MORE; w.jump = STEP_RD_NL; w.next = STEP_RD_LAST;
        w.rd_next = 1'b1; w.cmp_best = 1'b1;
      end
      STEP_RD_LAST: begin
        w.cond = COND_ALWAYS; w.jump = STEP_MUL_G; w.next = STEP_MUL_G;
        w.cmp_best = 1'b1;
      end
      STEP_MUL_G: begin
        w.cond = COND_ALWAYS; w.jump = STEP_TGT; w.next = STEP_TGT;
        w.mul_g = 1'b1;
      end
      STEP_TGT: begin
        w.cond = COND_ALWAYS; w.jump = STEP_DIFF; w.next = STEP_DIFF;
        w.ld_tgt = 1'b1;
      end
      STEP_DIFF: begin
        w.cond = COND_ALWAYS; w.jump = STEP_MUL_A; w.next = STEP_MUL_A;
        w.ld_diff = 1'b1;
      end
      STEP_MUL_A: begin
        w.cond = COND_ALWAYS; w.jump = STEP_NEWQ; w.next = STEP_NEWQ;
        w.mul_a = 1'b1;
      end
      STEP_NEWQ: begin
        w.cond = COND_ALWAYS; w.jump = STEP_WR; w.next = STEP_WR;
        w.ld_newq = 1'b1;
      end
      STEP_WR: begin
        w.cond = COND_ALWAYS; w.jump = STEP_SQ; w.next = STEP_SQ;
        w.q_wr = 1'b1;
      end
      STEP_SQ: begin
        w.cond = COND_ALWAYS; w.jump = STEP_OUT; w.next = STEP_OUT;
        w.ld_sq = 1'b1;
      end
      STEP_OUT: begin
        w.cond = COND_OUT_BUSY; w.jump = STEP_OUT; w.next = STEP_IDLE;
        w.ld_out = 1'b1;
      end
      default: begin
        w.cond = COND_ALWAYS; w.jump = STEP_IDLE; w.next = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // remainder of a small index by a constant, restoring subtraction
  function automatic logic [7:0] reduce_index(input logic [7:0] x, input int unsigned n);
    logic [24:0] r;
    logic [24:0] d;
    r = {17'd0, x};
    for (int b = 7; b >= 0; b--) begin
      d = 25'(n) << b;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[7:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
      r = v[31:0];
    end else if (v[35]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [16:0] clamp_rate(input logic [16:0] v);
    logic [16:0] r;
    r = (v[16] && (v[15:0] != 16'd0)) ? RATE_ONE : v;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/qtu_ram.sv
// ----------------------------------------------------------------------------
// qtu_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module qtu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/qtu_sequencer.sv
// ----------------------------------------------------------------------------
// qtu_sequencer
// step counter over the microcode table with conditional jumps
// ----------------------------------------------------------------------------
`default_nettype none

module qtu_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire qtu_pkg::status_t status,
  output qtu_pkg::ctrl_t        ctrl
);

  qtu_pkg::step_t step;
  qtu_pkg::step_t step_next;
  logic           take_jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= qtu_pkg::STEP_CLR;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = qtu_pkg::ucode(step);
    case (ctrl.cond)
      qtu_pkg::COND_ALWAYS:    take_jump = 1'b1;
      qtu_pkg::COND_WAIT_IN:   take_jump = !status.in_valid;
      qtu_pkg::COND_CLR_MORE:  take_jump = !status.clr_last;
      qtu_pkg::COND_SCAN_MORE: take_jump = !status.scan_last;
      qtu_pkg::COND_OUT_BUSY:  take_jump = status.out_busy;
      default:                 take_jump = 1'b0;
    endcase
    step_next = take_jump ? ctrl.jump : ctrl.next;
  end

endmodule

`default_nettype wire

>>> rtl/core/qtu_datapath.sv
// ----------------------------------------------------------------------------
// qtu_datapath
// q table, index capture, max scan, update arithmetic and output register
// ----------------------------------------------------------------------------
`default_nettype none

module qtu_datapath #(
  parameter int NUM_STATES  = 256,
  parameter int NUM_ACTIONS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire qtu_pkg::ctrl_t   ctrl,
  output qtu_pkg::status_t      status,
  input  wire logic             s_tvalid,
  input  wire logic [55:0]      s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [95:0]      m_tdata,
  input  wire logic [16:0]      learning_rate,
  input  wire logic [16:0]      discount_factor
);

  localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(NUM_ACTIONS + 1);

  logic               accept;
  logic [7:0]         cur_idx;
  logic [7:0]         fol_idx;
  logic [7:0]         act_idx;

  logic [AW-1:0]      slot_r;
  logic [AW-1:0]      nbase_r;
  logic signed [31:0] rew_r;
  logic [KW-1:0]      k_r;
  logic [AW-1:0]      clr_addr;
  logic signed [31:0] q_r;
  logic signed [31:0] best_r;
  logic [47:0]        prod_g;
  logic signed [33:0] tgt_r;
  logic signed [34:0] diff_r;
  logic signed [31:0] tsat_r;
  logic signed [52:0] prod_a;
  logic signed [31:0] newq_r;
  logic [32:0]        mag_r;
  logic [49:0]        sq_r;
  logic               big_r;
  logic               out_valid;
  logic [95:0]        out_data;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        ram_rdata;
  logic signed [31:0] rd_val;
  logic signed [17:0] lr_s;
  logic signed [34:0] delta;
  logic signed [32:0] err;
  logic [31:0]        loss;

  assign accept  = ctrl.in_ready && s_tvalid;
  assign cur_idx = qtu_pkg::reduce_index(s_tdata[7:0], NUM_STATES);
  assign fol_idx = qtu_pkg::reduce_index(s_tdata[15:8], NUM_STATES);
  assign act_idx = qtu_pkg::reduce_index({5'd0, s_tdata[18:16]}, NUM_ACTIONS);

  assign ram_we    = ctrl.clr_wr || ctrl.q_wr;
  assign ram_waddr = ctrl.clr_wr ? clr_addr : slot_r;
  assign ram_wdata = ctrl.clr_wr ? 32'd0 : newq_r;
  assign ram_raddr = ctrl.rd_next ? (nbase_r + AW'(k_r)) : slot_r;
  assign rd_val    = $signed(ram_rdata);

  qtu_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign lr_s  = $signed({1'b0, learning_rate});
  assign delta = prod_a[50:16];
  assign err   = 33'(newq_r) - 33'(tsat_r);
  assign loss  = (big_r || sq_r[49]) ? 32'hFFFF_FFFF : sq_r[48:17];

  assign status.in_valid  = s_tvalid;
  assign status.clr_last  = (clr_addr == AW'(DEPTH - 1));
  assign status.scan_last = (k_r == KW'(NUM_ACTIONS - 1));
  assign status.out_busy  = out_valid && !m_tready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      k_r       <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        k_r <= '0;
      end else if (ctrl.rd_next) begin
        k_r <= k_r + KW'(1);
      end
      if (ctrl.clr_wr) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (ctrl.ld_out && !status.out_busy) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r  <= AW'(cur_idx) * AW'(NUM_ACTIONS) + AW'(act_idx);
      nbase_r <= AW'(fol_idx) * AW'(NUM_ACTIONS);
      rew_r   <= $signed(s_tdata[50:19]);
      best_r  <= '0;
    end else if (ctrl.cmp_best && (rd_val > best_r)) begin
      best_r <= rd_val;
    end
    if (ctrl.ld_q) begin
      q_r <= rd_val;
    end
    if (ctrl.mul_g) begin
      prod_g <= 48'(discount_factor) * 48'(best_r[30:0]);
    end
    if (ctrl.ld_tgt) begin
      tgt_r <= 34'(rew_r) + $signed({2'b00, prod_g[47:16]});
    end
    if (ctrl.ld_diff) begin
      diff_r <= 35'(tgt_r) - 35'(q_r);
      tsat_r <= $signed(qtu_pkg::sat32(36'(tgt_r)));
    end
    if (ctrl.mul_a) begin
      prod_a <= 53'(lr_s) * 53'(diff_r);
    end
    if (ctrl.ld_newq) begin
      newq_r <= $signed(qtu_pkg::sat32(36'(q_r) + 36'(delta)));
    end
    if (ctrl.q_wr) begin
      mag_r <= err[32] ? 33'(-err) : 33'(err);
    end
    if (ctrl.ld_sq) begin
      sq_r  <= 50'(mag_r[24:0]) * 50'(mag_r[24:0]);
      big_r <= |mag_r[32:25];
    end
    if (ctrl.ld_out && !status.out_busy) begin
      out_data <= {loss, tsat_r, newq_r};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

>>> rtl/core/q_table_update.sv
// ----------------------------------------------------------------------------
// q_table_update
// tabular q learning update over a dense q table held in ram
// ----------------------------------------------------------------------------
// channel   dir  bits  words
// s_*       in   56    one update request
// m_*       out  96    new q, target and loss of that request
// cfg_*     in   17    learning rate and discount factor writes
//
// an update presents its result once the next-state row has been scanned through
// the single ram read port and the steps that follow are done; the next request
// can be taken as soon as that result is presented.
// after reset a clearing pass writes zero to all NUM_STATES*NUM_ACTIONS entries
// with s_tready low; cfg writes are taken. a result waiting in the output
// register does not block the next request; the sequencer holds at its output
// step only while that result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module q_table_update #(
  parameter int NUM_STATES  = 256,
  parameter int NUM_ACTIONS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // current_state[7:0], following_state[15:8], action_index[18:16],
  // reward_value[50:19], zero fill[55:51]
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // updated_q[31:0], target_value[63:32], loss_value[95:64]
  output logic      [95:0] m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);

  qtu_pkg::ctrl_t   ctrl;
  qtu_pkg::status_t status;
  logic [16:0]      learning_rate;
  logic [16:0]      discount_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate   <= qtu_pkg::LR_RESET;
      discount_factor <= qtu_pkg::DF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qtu_pkg::CFG_LEARNING_RATE:   learning_rate   <= qtu_pkg::clamp_rate(cfg_data);
        qtu_pkg::CFG_DISCOUNT_FACTOR: discount_factor <= qtu_pkg::clamp_rate(cfg_data);
        default: begin
        end
      endcase
    end
  end

  assign s_tready = ctrl.in_ready;

  qtu_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  qtu_datapath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .status          (status),
    .s_tvalid        (s_tvalid),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .learning_rate   (learning_rate),
    .discount_factor (discount_factor)
  );

endmodule

`default_nettype wire

>>> rtl/core/qtu_checker.sv
// ----------------------------------------------------------------------------
// qtu_checker
// port level checks of the q table update block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qtu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata
);

  `QTU_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> (!m_tvalid && !s_tready), "busy after reset")
  `QTU_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled word changed")
  `QTU_ASSERT(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "second word taken during update")
  `QTU_ASSERT(a_zero_loss, clk, rst, (m_tvalid && (m_tdata[31:0] == m_tdata[63:32])) |-> (m_tdata[95:64] == 32'd0), "loss nonzero with zero error")

endmodule

bind q_table_update qtu_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
